// File: hdl/uer_pkg.sv
`timescale 1ns / 1ps
package uer_pkg;

  // Echo counter width and its saturation value
  localparam int COUNTER_BITS = 24;
  localparam logic [COUNTER_BITS-1:0] CNT_MAX = {COUNTER_BITS{1'b1}};

  // Configuration registers
  localparam int TRIG_W  = 16;
  localparam int SCALE_W = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_TICKS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR  = 1'b1;
  localparam logic [TRIG_W-1:0]  TRIGGER_TICKS_RST = 16'd800;
  localparam logic [SCALE_W-1:0] SCALE_FACTOR_RST  = 32'd920734;

  // Stream widths
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 16;

  // Distance arithmetic
  localparam int PROD_W = COUNTER_BITS + SCALE_W;
  localparam int DIST_W = 10;
  localparam logic [DIST_W-1:0] DIST_MAX = 10'd999;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic trig;
    logic busy;
    logic done;
  } uer_flags_t;

  typedef struct packed {
    uer_flags_t              flags;
    logic [COUNTER_BITS-1:0] count;
  } uer_item_t;

endpackage

// File: hdl/uer_front.sv
`timescale 1ns / 1ps
module uer_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  logic                         start_request,
  input  logic                         echo_level,
  input  logic [uer_pkg::TRIG_W-1:0]   trigger_ticks,
  output uer_pkg::uer_item_t           item
);
  import uer_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRIG_LOW,
    ST_TRIG_HIGH,
    ST_WAIT_ECHO,
    ST_COUNT
  } state_t;

  state_t                  state_r, state_nxt;
  logic [COUNTER_BITS-1:0] cnt_r, cnt_nxt;
  logic [COUNTER_BITS-1:0] cnt_inc;
  logic [TRIG_W-1:0]       lim;
  logic                    phase_end;

  // Trigger phase length, zero taken as one tick
  assign lim       = (trigger_ticks == '0) ? TRIG_W'(1) : trigger_ticks;
  assign cnt_inc   = cnt_r + COUNTER_BITS'(1);
  assign phase_end = (cnt_inc >= COUNTER_BITS'(lim));

  // Classify this tick and pick the next phase
  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    item.flags.trig = 1'b0;
    item.flags.busy = 1'b1;
    item.flags.done = 1'b0;
    item.count      = '0;
    unique case (state_r)
      ST_TRIG_LOW: begin
        if (phase_end) begin
          state_nxt = ST_TRIG_HIGH;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
      ST_TRIG_HIGH: begin
        item.flags.trig = 1'b1;
        if (phase_end) begin
          state_nxt = ST_WAIT_ECHO;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
      ST_WAIT_ECHO: begin
        if (echo_level) begin
          state_nxt = ST_COUNT;
          cnt_nxt   = COUNTER_BITS'(1);
        end
      end
      ST_COUNT: begin
        if (echo_level) begin
          if (cnt_r != CNT_MAX) begin
            cnt_nxt = cnt_inc;
          end
        end else begin
          item.flags.busy = 1'b0;
          item.flags.done = 1'b1;
          item.count      = cnt_r;
          state_nxt       = ST_IDLE;
          cnt_nxt         = '0;
        end
      end
      default: begin
        // Idle, or a stray state code: the start tick is the first low tick
        state_nxt = ST_IDLE;
        cnt_nxt   = '0;
        if (start_request) begin
          if (phase_end) begin
            state_nxt = ST_TRIG_HIGH;
          end else begin
            state_nxt = ST_TRIG_LOW;
            cnt_nxt   = cnt_inc;
          end
        end else begin
          item.flags.busy = 1'b0;
        end
      end
    endcase
  end

  // Advance only on an input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else if (accept) begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// File: hdl/uer_queue.sv
`timescale 1ns / 1ps
module uer_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  uer_pkg::uer_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output uer_pkg::uer_item_t pop_item
);
  import uer_pkg::*;

  uer_item_t         mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push, do_pop;

  assign full      = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_item  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

endmodule

// File: hdl/uer_back.sv
`timescale 1ns / 1ps
module uer_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            item_valid,
  input  uer_pkg::uer_item_t              item,
  output logic                            item_ready,
  input  logic [uer_pkg::SCALE_W-1:0]     scale_factor,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [uer_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import uer_pkg::*;

  // Stage 1: scaled distance
  logic                    v1_r;
  uer_flags_t              f1_r;
  logic [COUNTER_BITS-1:0] dist1_r;
  logic                    sat1_r;
  logic [PROD_W-1:0]       prod;

  // Stage 2: clamp and hundreds digit
  logic              v2_r;
  uer_flags_t        f2_r;
  logic              over2_r;
  logic [3:0]        hund2_r;
  logic [6:0]        rem2_r;
  logic              over2;
  logic [DIST_W-1:0] dist2;
  logic [15:0]       hund_prod;
  logic [3:0]        hund2;
  logic [DIST_W-1:0] hund_x100;

  // Stage 3: tens, units and held digits, also the output register
  logic        v3_r;
  uer_flags_t  f3_r;
  logic [3:0]  hund3_r, tens3_r, units3_r;
  logic        over3_r;
  logic [3:0]  hund_held_r, tens_held_r, units_held_r;
  logic        over_held_r;
  logic [14:0] tens_prod;
  logic [3:0]  tens3;
  logic [6:0]  tens_x10;
  logic [3:0]  units3;

  logic ready1, ready2, ready3;

  // Stall chain: a stage moves when the one after it has room
  assign ready3     = !v3_r || out_tready;
  assign ready2     = !v2_r || ready3;
  assign ready1     = !v1_r || ready2;
  assign item_ready = ready1;

  assign prod = PROD_W'(item.count) * PROD_W'(scale_factor);

  // Clamp to three digits, hundreds = d * 41 >> 12 for d below 1000
  assign over2     = sat1_r || (dist1_r > COUNTER_BITS'(DIST_MAX));
  assign dist2     = over2 ? DIST_MAX : dist1_r[DIST_W-1:0];
  assign hund_prod = 16'(dist2) * 16'd41;
  assign hund2     = hund_prod[15:12];
  assign hund_x100 = DIST_W'(hund2) * DIST_W'(100);

  // Tens = r * 205 >> 11 for r below 100
  assign tens_prod = 15'(rem2_r) * 15'd205;
  assign tens3     = tens_prod[14:11];
  assign tens_x10  = 7'(tens3) * 7'd10;
  assign units3    = 4'(rem2_r - tens_x10);

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (ready1) begin
        v1_r <= item_valid;
      end
      if (ready2) begin
        v2_r <= v1_r;
      end
      if (ready3) begin
        v3_r <= v2_r;
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (ready1) begin
      f1_r    <= item.flags;
      dist1_r <= prod[PROD_W-1:SCALE_W];
      sat1_r  <= (item.count == CNT_MAX);
    end
    if (ready2) begin
      f2_r    <= f1_r;
      over2_r <= over2;
      hund2_r <= hund2;
      rem2_r  <= 7'(dist2 - hund_x100);
    end
    if (ready3) begin
      f3_r <= f2_r;
      if (f2_r.done) begin
        hund3_r  <= hund2_r;
        tens3_r  <= tens3;
        units3_r <= units3;
        over3_r  <= over2_r;
      end else begin
        hund3_r  <= hund_held_r;
        tens3_r  <= tens_held_r;
        units3_r <= units_held_r;
        over3_r  <= over_held_r;
      end
    end
  end

  // Held distance, replaced on a completed measurement
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hund_held_r  <= '0;
      tens_held_r  <= '0;
      units_held_r <= '0;
      over_held_r  <= 1'b0;
    end else if (ready3 && v2_r && f2_r.done) begin
      hund_held_r  <= hund2_r;
      tens_held_r  <= tens3;
      units_held_r <= units3;
      over_held_r  <= over2_r;
    end
  end

  assign out_tvalid = v3_r;
  assign out_tdata  = {over3_r, units3_r, tens3_r, hund3_r, f3_r.done, f3_r.busy, f3_r.trig};

endmodule

// File: hdl/ultrasonic_echo_ranging_top.sv
`timescale 1ns / 1ps
// A result is offered from the stage 3 register after the queue and stages 1 and 2.
// Throughput: one tick item per cycle while the queue has room (in_tready high);
// the front phase machine takes a tick per transfer and the three-stage distance pipeline a result per unstalled cycle.
// Reset (rst_n low, synchronous) returns to idle with zero digits, clears the
// queue and pipeline and reloads trigger_ticks = 800, scale_factor = 920734.
module ultrasonic_echo_ranging_top (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata: [0] start_request, [1] echo_level, [7:2] zero
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [uer_pkg::IN_DATA_W-1:0]      in_tdata,
  // out_tdata: [0] trigger_out, [1] busy_res, [2] done_res, [6:3] hundreds,
  // [10:7] tens, [14:11] units, [15] overrange
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [uer_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                               cfg_wr_en,
  input  logic [uer_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [uer_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import uer_pkg::*;

  logic [TRIG_W-1:0]  trigger_ticks_r;
  logic [SCALE_W-1:0] scale_factor_r;
  logic               accept;
  logic               q_full, q_not_empty, q_pop;
  uer_item_t          front_item, q_item;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trigger_ticks_r <= TRIGGER_TICKS_RST;
      scale_factor_r  <= SCALE_FACTOR_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_TRIGGER_TICKS: trigger_ticks_r <= cfg_wdata[TRIG_W-1:0];
        REG_SCALE_FACTOR:  scale_factor_r  <= cfg_wdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  uer_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .start_request (in_tdata[0]),
    .echo_level    (in_tdata[1]),
    .trigger_ticks (trigger_ticks_r),
    .item          (front_item)
  );

  uer_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_item  (q_item)
  );

  uer_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (q_not_empty),
    .item         (q_item),
    .item_ready   (q_pop),
    .scale_factor (scale_factor_r),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata)
  );

  // A full queue only arises behind a stalled result
  a_full_needs_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("queue full while no result is waiting");

  // A completing tick is never reported busy
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[2] && out_tdata[1]))
    else $error("result marked both done and busy");

  // Digits stay decimal
  a_digits_decimal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[6:3] <= 4'd9 && out_tdata[10:7] <= 4'd9 &&
                    out_tdata[14:11] <= 4'd9))
    else $error("distance digit above nine");

  // Overrange reads as 999
  a_over_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[15]) |->
      (out_tdata[6:3] == 4'd9 && out_tdata[10:7] == 4'd9 && out_tdata[14:11] == 4'd9))
    else $error("overrange without clamped distance");

endmodule
